>>> hw/rtl/mkmr_pkg.sv
// Shared types and constants of the multicast key/mask router.
`default_nettype none

package mkmr_pkg;

    // Request operation codes
    localparam logic OP_ROUTE = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Field widths fixed by the interface
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned PAYLOAD_W = 32;
    localparam int unsigned INDEX_W   = 10;
    localparam int unsigned ROUTE_W   = 24;
    localparam int unsigned LINK_W    = 6;
    localparam int unsigned CORE_W    = 18;

    // Reset values
    localparam logic [KEY_W-1:0]  NEVER_KEY      = 32'hFFFF_FFFF;
    localparam logic [LINK_W-1:0] LINK_EN_RESET  = 6'h3F;

    // One request: either a table write or a packet to route
    typedef struct packed {
        logic                 opcode;
        logic [KEY_W-1:0]     packet_key;
        logic [PAYLOAD_W-1:0] packet_payload;
        logic                 payload_present;
        logic [INDEX_W-1:0]   entry_index;
        logic [KEY_W-1:0]     entry_key;
        logic [KEY_W-1:0]     entry_mask;
        logic [ROUTE_W-1:0]   entry_route;
    } t_req;

    // One routing result
    typedef struct packed {
        logic                 matched;
        logic [LINK_W-1:0]    link_targets;
        logic [CORE_W-1:0]    core_targets;
        logic [KEY_W-1:0]     out_key;
        logic [PAYLOAD_W-1:0] out_payload;
        logic                 out_payload_present;
    } t_rsp;

    // One routing table entry as held in memory
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   mask;
        logic [ROUTE_W-1:0] route;
    } t_entry;

    // Entry contents that can never match any packet key
    localparam t_entry CLEAR_ENTRY = '{key: NEVER_KEY, mask: '0, route: '0};

endpackage

`default_nettype wire

>>> hw/rtl/mkmr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mkmr_ram #(
    parameter int unsigned WIDTH = 88,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: hold data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/multicast_key_mask_router_top.sv
// Top level of the multicast key/mask first-match router.
// A table write request is taken in the idle state. A route request searches
// the table in index order, one entry per cycle through the single read port
// of the table memory, and stops at the first hit or at the last entry (miss);
// the search holds there until the output register is free. The next request
// is taken as soon as the search ends, while the result waits in the output
// register. After reset a clearing pass over every entry fills the table with
// never-matching entries; no request is taken during it, though the link
// enable register can be written at any time.
`default_nettype none

module multicast_key_mask_router_top
    import mkmr_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 1024,
    parameter int unsigned LINK_COUNT    = 6,
    parameter int unsigned CORE_COUNT    = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire t_req              i_req,
    // result channel
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output t_rsp                   o_rsp,
    // link enable write channel
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [LINK_W-1:0] i_cfg_data
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);
    localparam logic [63:0] LINK_MASK = (64'd1 << LINK_COUNT) - 64'd1;
    localparam logic [63:0] CORE_MASK = (64'd1 << CORE_COUNT) - 64'd1;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_SEARCH = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic [LINK_W-1:0]   r_link_enable;
    logic [KEY_W-1:0]    r_key;
    logic [PAYLOAD_W-1:0] r_payload;
    logic                r_present;
    logic                r_rsp_valid;
    t_rsp                r_rsp;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry              rd_entry;

    logic                req_take;
    logic                slot_free;
    logic                hit;
    logic                last;
    logic                load_rsp;
    logic [63:0]         route64;
    t_rsp                n_rsp;

    // Routing table
    mkmr_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = t_entry'(ram_rdata);
    assign req_take  = i_req_valid && o_req_ready;
    assign slot_free = !r_rsp_valid || i_rsp_ready;

    // Compare the entry just read against the held packet key
    assign hit  = (rd_entry.key == (r_key & rd_entry.mask));
    assign last = (r_addr == LAST_ADDR);

    // Sequence clearing, writes and the search
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = CLEAR_ENTRY;
        ram_re      = 1'b0;
        ram_raddr   = r_addr;
        load_rsp    = 1'b0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (last) begin
                    n_state = ST_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req.opcode == OP_WRITE) begin
                        ram_we    = (32'(i_req.entry_index) < 32'(TABLE_ENTRIES));
                        ram_waddr = AW'(i_req.entry_index);
                        ram_wdata = '{key:   i_req.entry_key,
                                      mask:  i_req.entry_mask,
                                      route: i_req.entry_route};
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_addr    = '0;
                        n_state   = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (hit || last) begin
                    // hold until the output register can take the result
                    if (slot_free) begin
                        load_rsp = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr + AW'(1);
                    n_addr    = r_addr + AW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Build the result from the deciding entry
    assign route64 = 64'(rd_entry.route);
    always_comb begin
        n_rsp.matched             = hit;
        n_rsp.link_targets        = hit ? LINK_W'(route64 & LINK_MASK & 64'(r_link_enable))
                                        : '0;
        n_rsp.core_targets        = hit ? CORE_W'((route64 >> LINK_COUNT) & CORE_MASK) : '0;
        n_rsp.out_key             = r_key;
        n_rsp.out_payload         = r_present ? r_payload : '0;
        n_rsp.out_payload_present = r_present;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_addr        <= '0;
            r_link_enable <= LINK_EN_RESET;
            r_rsp_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            if (i_cfg_valid) begin
                r_link_enable <= i_cfg_data;
            end
            if (load_rsp) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Capture the packet and the result
    always_ff @(posedge i_clk) begin
        if (req_take && (i_req.opcode == OP_ROUTE)) begin
            r_key     <= i_req.packet_key;
            r_payload <= i_req.packet_payload;
            r_present <= i_req.payload_present;
        end
        if (load_rsp) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // A result only ever follows a search
    a_rsp_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state == ST_SEARCH))
        else $error("result raised without a search");

    // A dropped packet drives no link and no core
    a_miss_no_targets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.matched) |->
        (o_rsp.link_targets == '0 && o_rsp.core_targets == '0))
        else $error("dropped packet carries targets");

    // The table is never written while a search reads it
    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> !ram_we)
        else $error("table write during search");

    // No request is taken during the clearing pass
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !req_take)
        else $error("request taken while clearing");

    // A stalled search holds its read data
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH && (hit || last) && !slot_free) |=>
        ($stable(r_addr) && $stable(ram_rdata)))
        else $error("stalled search lost its entry");

endmodule

`default_nettype wire

>>> tb/sv/mkmr_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the router's results.
package mkmr_tb_pkg;
    import mkmr_pkg::*;

    localparam int unsigned ROUTE_TABLE_DEPTH = 1024;
    localparam int unsigned TBL_AW            = $clog2(ROUTE_TABLE_DEPTH);

    class route_lookup_scoreboard;
        logic [KEY_W-1:0]   tbl_key   [ROUTE_TABLE_DEPTH];
        logic [KEY_W-1:0]   tbl_mask  [ROUTE_TABLE_DEPTH];
        logic [ROUTE_W-1:0] tbl_route [ROUTE_TABLE_DEPTH];
        logic [LINK_W-1:0]  link_en_shadow;
        t_rsp               pending_routes [$];
        int unsigned        mismatch_count;

        // Start from the post-reset table: every entry a key that never matches
        function new();
            int unsigned i;
            for (i = 0; i < ROUTE_TABLE_DEPTH; i++) begin
                tbl_key[TBL_AW'(i)]   = NEVER_KEY;
                tbl_mask[TBL_AW'(i)]  = '0;
                tbl_route[TBL_AW'(i)] = '0;
            end
            link_en_shadow = LINK_EN_RESET;
            mismatch_count = 0;
        endfunction

        function void set_link_enable(logic [LINK_W-1:0] value);
            link_en_shadow = value;
        endfunction

        function int unsigned outstanding();
            return pending_routes.size();
        endfunction

        // Apply a table write, or search the table and queue the routing result
        function void note_request(t_req r);
            t_rsp        exp_rsp;
            logic        hit;
            int unsigned i;
            if (r.opcode == OP_WRITE) begin
                tbl_key[r.entry_index]   = r.entry_key;
                tbl_mask[r.entry_index]  = r.entry_mask;
                tbl_route[r.entry_index] = r.entry_route;
                return;
            end
            exp_rsp = '0;
            hit     = 1'b0;
            // first match in index order decides
            for (i = 0; i < ROUTE_TABLE_DEPTH; i++) begin
                if (!hit && tbl_key[TBL_AW'(i)] == (r.packet_key & tbl_mask[TBL_AW'(i)])) begin
                    hit                  = 1'b1;
                    exp_rsp.matched      = 1'b1;
                    exp_rsp.link_targets = tbl_route[TBL_AW'(i)][LINK_W-1:0] & link_en_shadow;
                    exp_rsp.core_targets = tbl_route[TBL_AW'(i)][LINK_W +: CORE_W];
                end
            end
            exp_rsp.out_key             = r.packet_key;
            exp_rsp.out_payload         = r.payload_present ? r.packet_payload : '0;
            exp_rsp.out_payload_present = r.payload_present;
            pending_routes.push_back(exp_rsp);
        endfunction

        function void compare_field(string label, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, label, exp_v, got_v);
                mismatch_count++;
            end
        endfunction

        // Compare a result against the oldest outstanding prediction
        function void check_result(t_rsp got);
            t_rsp exp_rsp;
            if (pending_routes.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                mismatch_count++;
                return;
            end
            exp_rsp = pending_routes.pop_front();
            compare_field("matched", 32'(exp_rsp.matched), 32'(got.matched));
            compare_field("link_targets", 32'(exp_rsp.link_targets),
                          32'(got.link_targets));
            compare_field("core_targets", 32'(exp_rsp.core_targets),
                          32'(got.core_targets));
            compare_field("out_key", exp_rsp.out_key, got.out_key);
            compare_field("out_payload", exp_rsp.out_payload, got.out_payload);
            compare_field("out_payload_present", 32'(exp_rsp.out_payload_present),
                          32'(got.out_payload_present));
        endfunction
    endclass

endpackage

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for the multicast key/mask first-match router.
module tb;
    import mkmr_pkg::*;
    import mkmr_tb_pkg::*;

    localparam int unsigned CLK_HALF       = 5;
    localparam int unsigned PHASES         = 5;
    localparam int unsigned PHASE_REQUESTS = 112;
    localparam int unsigned TRACKED_SLOTS  = 32;
    localparam int unsigned SLOT_W         = $clog2(TRACKED_SLOTS);
    localparam int unsigned MAX_GAP        = 20;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_req_valid = 1'b0;
    logic              o_req_ready;
    t_req              i_req       = '0;
    logic              o_rsp_valid;
    logic              i_rsp_ready = 1'b0;
    t_rsp              o_rsp;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [LINK_W-1:0] i_cfg_data  = '0;

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;

    // Keys and masks last written to the low table slots, used to aim packets at hits
    logic [KEY_W-1:0] slot_key  [TRACKED_SLOTS];
    logic [KEY_W-1:0] slot_mask [TRACKED_SLOTS];

    route_lookup_scoreboard sb;

    multicast_key_mask_router_top #(
        .TABLE_ENTRIES (ROUTE_TABLE_DEPTH),
        .LINK_COUNT    (LINK_W),
        .CORE_COUNT    (CORE_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Note accepted requests and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && i_req_valid && o_req_ready)
            sb.note_request(i_req);
        if (i_rst_n && o_rsp_valid && i_rsp_ready)
            sb.check_result(o_rsp);
    end

    // Present one request after a random gap and hold it until accepted
    task automatic send_request(input t_req r);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    task automatic post_route(input logic [KEY_W-1:0] key,
                              input logic [PAYLOAD_W-1:0] payload,
                              input logic present);
        t_req r;
        r.opcode          = OP_ROUTE;
        r.packet_key      = key;
        r.packet_payload  = payload;
        r.payload_present = present;
        // entry fields are don't-care on a route
        r.entry_index     = INDEX_W'($urandom);
        r.entry_key       = $urandom;
        r.entry_mask      = $urandom;
        r.entry_route     = ROUTE_W'($urandom);
        send_request(r);
    endtask

    task automatic post_write(input logic [INDEX_W-1:0] index,
                              input logic [KEY_W-1:0] key,
                              input logic [KEY_W-1:0] mask,
                              input logic [ROUTE_W-1:0] route);
        t_req r;
        r.opcode          = OP_WRITE;
        r.packet_key      = $urandom;
        r.packet_payload  = $urandom;
        r.payload_present = 1'($urandom_range(0, 1));
        r.entry_index     = index;
        r.entry_key       = key;
        r.entry_mask      = mask;
        r.entry_route     = route;
        if (32'(index) < TRACKED_SLOTS) begin
            slot_key[index[SLOT_W-1:0]]  = key;
            slot_mask[index[SLOT_W-1:0]] = mask;
        end
        send_request(r);
    endtask

    task automatic write_link_enable(input logic [LINK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_link_enable(value);
    endtask

    // Drop valid, wait for every outstanding result, then let a table write settle
    task automatic wait_idle();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int unsigned        phase;
        int unsigned        n;
        int unsigned        pick;
        int unsigned        slot;
        logic [INDEX_W-1:0] idx;
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   mask;
        logic [LINK_W-1:0]  link_value;

        sb = new();
        for (n = 0; n < TRACKED_SLOTS; n++) begin
            slot_key[SLOT_W'(n)]  = NEVER_KEY;
            slot_mask[SLOT_W'(n)] = '0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_link_enable(LINK_EN_RESET);

        // Directed: misses on the cleared table, extreme keys and indices,
        // a catch-all entry at the far end, overwrites and shadowed entries
        post_route(32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b1);
        post_route(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        post_write(10'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
        post_route(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        post_write(10'd1023, 32'h0000_0000, 32'h0000_0000, 24'h00_0041);
        post_route(32'h1234_5678, 32'h1234_5678, 1'b1);
        post_write(10'd1, 32'hA5A5_0000, 32'hFFFF_0000, 24'hAA_AAAA);
        post_route(32'hA5A5_FFFF, 32'h5A5A_5A5A, 1'b1);
        post_write(10'd2, 32'h0000_0001, 32'h0000_0001, 24'h55_5555);
        post_route(32'h0000_0003, 32'hFFFF_FFFF, 1'b1);
        // key with bits outside its mask: entry can never match
        post_write(10'd0, 32'h0000_0012, 32'h0000_0000, 24'hFF_FFFF);
        post_route(32'hFFFF_FFFF, 32'h8000_0001, 1'b0);
        post_write(10'd1023, NEVER_KEY, 32'h0000_0000, 24'h00_0000);
        post_route(32'h1234_5678, 32'hCAFE_F00D, 1'b1);
        post_write(10'h2AA, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 24'h00_003F);
        post_route(32'hFFFF_FFFE, 32'h0123_4567, 1'b1);
        post_write(10'h155, 32'h0000_0000, 32'h0000_0000, 24'hFF_FFC0);
        post_route(32'h0000_0000, 32'h7654_3210, 1'b0);
        post_write(10'h155, NEVER_KEY, 32'h0000_0000, 24'h00_0000);
        post_route(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        wait_idle();

        // Random phases, each under its own idling pattern and link enable
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;  link_value = 6'h00;
                end
                1: begin
                    sender_idle_pct = 71; receiver_stall_pct = 0;  link_value = 6'h2A;
                end
                2: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 71; link_value = 6'h15;
                end
                3: begin
                    sender_idle_pct = 31; receiver_stall_pct = 31;
                    link_value = LINK_W'($urandom);
                end
                default: begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;  link_value = LINK_EN_RESET;
                end
            endcase
            write_link_enable(link_value);

            for (n = 0; n < PHASE_REQUESTS; n++) begin
                if ($urandom_range(0, 99) < 25) begin
                    // table write, mostly to the low slots that packets aim at
                    pick = $urandom_range(0, 99);
                    if (pick < 85)
                        idx = INDEX_W'($urandom_range(0, TRACKED_SLOTS - 1));
                    else if (pick < 95)
                        idx = INDEX_W'($urandom_range(0, ROUTE_TABLE_DEPTH - 1));
                    else
                        idx = INDEX_W'(ROUTE_TABLE_DEPTH - 1);
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        mask = '0;
                    else if (pick < 3)
                        mask = '1;
                    else if (pick < 11)
                        mask = $urandom;
                    else
                        mask = 32'hFFFF_FFFF << $urandom_range(0, 31);
                    key = ($urandom_range(0, 9) < 8) ? ($urandom & mask) : $urandom;
                    post_write(idx, key, mask, ROUTE_W'($urandom));
                end else begin
                    // packet aimed at a written slot, or a random key
                    if ($urandom_range(0, 99) < 70) begin
                        slot = $urandom_range(0, TRACKED_SLOTS - 1);
                        key  = slot_key[SLOT_W'(slot)] |
                               ($urandom & ~slot_mask[SLOT_W'(slot)]);
                    end else begin
                        key = $urandom;
                    end
                    post_route(key, $urandom, 1'($urandom_range(0, 1)));
                end
            end
            wait_idle();
        end

        repeat (16) @(posedge i_clk);
        if (sb.mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Abort a hung run
    initial begin
        #(40_000_000);
        $display("Timeout at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mkmr_pkg.sv
hw/rtl/mkmr_ram.sv
hw/rtl/multicast_key_mask_router_top.sv
tb/sv/mkmr_tb_pkg.sv
tb/sv/tb.sv
